// ===== hw/rtl/mscs_pkg.sv =====
`timescale 1ns / 1ps

package mscs_pkg;

	// machine and memory geometry
	localparam int XLEN = 32;
	localparam int REGS = 32;
	localparam int REG_W = $clog2(REGS);
	localparam int BUDGET_W = 20;
	localparam int MEM_IDX_W = 10;
	localparam int DATA_WORDS = 1024;
	localparam logic [XLEN-1:0] DATA_BASE = 32'h1000_0000;
	localparam int DA_W = $clog2(DATA_WORDS);

	// clear pass after reset covers the larger of the two memories
	localparam int CLR_WORDS = (DATA_WORDS > REGS) ? DATA_WORDS : REGS;
	localparam int CLR_CNT_W = $clog2(CLR_WORDS + 1);

	// queue between decode and execute
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// stream widths
	localparam int IN_W = 32;
	localparam int RES_W = 116;
	localparam int OUT_W = 120;

	// special instruction words
	localparam logic [XLEN-1:0] INS_HALT = 32'hFFFF_FFFF;
	localparam logic [XLEN-1:0] INS_NOP = 32'h0000_0000;

	// primary opcodes
	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J = 6'd2;
	localparam logic [5:0] OP_BEQ = 6'd4;
	localparam logic [5:0] OP_BNE = 6'd5;
	localparam logic [5:0] OP_ADDI = 6'd8;
	localparam logic [5:0] OP_SLTI = 6'd10;
	localparam logic [5:0] OP_ANDI = 6'd12;
	localparam logic [5:0] OP_ORI = 6'd13;
	localparam logic [5:0] OP_LUI = 6'd15;
	localparam logic [5:0] OP_LW = 6'd35;
	localparam logic [5:0] OP_SW = 6'd43;

	// r-type function codes
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;
	localparam logic [5:0] FN_AND = 6'd36;
	localparam logic [5:0] FN_OR = 6'd37;
	localparam logic [5:0] FN_SLT = 6'd42;

	typedef enum logic [3:0] {
		K_NOP,
		K_HALT,
		K_BAD,
		K_ALU,
		K_JUMP,
		K_BEQ,
		K_BNE,
		K_LOAD,
		K_STORE
	} kind_t;

	typedef enum logic [2:0] {
		A_ADD,
		A_SUB,
		A_AND,
		A_OR,
		A_SLT,
		A_PASSB
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_HALT = 3'd1,
		ST_BAD_OP = 3'd2,
		ST_BUDGET = 3'd3,
		ST_BAD_ADDR = 3'd4
	} status_t;

	// decoded instruction; for loads and stores imm already has DATA_BASE taken off
	typedef struct packed {
		kind_t kind;
		alu_op_t alu_op;
		logic use_imm;
		logic [REG_W-1:0] rs;
		logic [REG_W-1:0] rt;
		logic [REG_W-1:0] dst;
		logic [XLEN-1:0] imm;
		logic [25:0] jidx;
	} uop_t;

	typedef struct packed {
		status_t status;
		logic [XLEN-1:0] mem_value;
		logic [MEM_IDX_W-1:0] mem_word_index;
		logic mem_write;
		logic [XLEN-1:0] reg_value;
		logic [REG_W-1:0] reg_index;
		logic reg_write;
		logic [XLEN-1:0] next_pc;
	} result_t;

endpackage

// ===== hw/rtl/mscs_ram.sv =====
`timescale 1ns / 1ps

module mscs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/mscs_front.sv =====
`timescale 1ns / 1ps

module mscs_front (
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [mscs_pkg::IN_W-1:0] s_axis_tdata, // instruction[31:0]
	input logic q_full,
	input logic busy,
	output logic push,
	output mscs_pkg::uop_t uop
);

	import mscs_pkg::*;

	logic [5:0] op;
	logic [5:0] fn;
	logic [XLEN-1:0] sext;
	logic [XLEN-1:0] zext;

	// take a request whenever the queue has room and the clear pass is done
	assign s_axis_tready = !q_full && !busy;
	assign push = s_axis_tvalid && s_axis_tready;

	assign op = s_axis_tdata[31:26];
	assign fn = s_axis_tdata[5:0];
	assign sext = {{16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
	assign zext = {16'b0, s_axis_tdata[15:0]};

	// classify the instruction word
	always_comb begin
		uop.kind = K_BAD;
		uop.alu_op = A_ADD;
		uop.use_imm = 1'b0;
		uop.rs = s_axis_tdata[25:21];
		uop.rt = s_axis_tdata[20:16];
		uop.dst = s_axis_tdata[20:16];
		uop.imm = sext;
		uop.jidx = s_axis_tdata[25:0];
		if (s_axis_tdata == INS_HALT) begin
			uop.kind = K_HALT;
		end else if (s_axis_tdata == INS_NOP) begin
			uop.kind = K_NOP;
		end else begin
			unique case (op)
				OP_RTYPE: begin
					uop.dst = s_axis_tdata[15:11];
					uop.kind = K_ALU;
					unique case (fn)
						FN_ADD: uop.alu_op = A_ADD;
						FN_SUB: uop.alu_op = A_SUB;
						FN_AND: uop.alu_op = A_AND;
						FN_OR: uop.alu_op = A_OR;
						FN_SLT: uop.alu_op = A_SLT;
						default: uop.kind = K_BAD;
					endcase
				end
				OP_J: uop.kind = K_JUMP;
				OP_BEQ: uop.kind = K_BEQ;
				OP_BNE: uop.kind = K_BNE;
				OP_ADDI: begin
					uop.kind = K_ALU;
					uop.use_imm = 1'b1;
				end
				OP_SLTI: begin
					uop.kind = K_ALU;
					uop.alu_op = A_SLT;
					uop.use_imm = 1'b1;
				end
				OP_ANDI: begin
					uop.kind = K_ALU;
					uop.alu_op = A_AND;
					uop.use_imm = 1'b1;
					uop.imm = zext;
				end
				OP_ORI: begin
					uop.kind = K_ALU;
					uop.alu_op = A_OR;
					uop.use_imm = 1'b1;
					uop.imm = zext;
				end
				OP_LUI: begin
					uop.kind = K_ALU;
					uop.alu_op = A_PASSB;
					uop.use_imm = 1'b1;
					uop.imm = {s_axis_tdata[15:0], 16'b0};
				end
				OP_LW: begin
					uop.kind = K_LOAD;
					uop.imm = sext - DATA_BASE;
				end
				OP_SW: begin
					uop.kind = K_STORE;
					uop.imm = sext - DATA_BASE;
				end
				default: uop.kind = K_BAD;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mscs_queue.sv =====
`timescale 1ns / 1ps

module mscs_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mscs_pkg::uop_t push_uop,
	output logic full,
	input logic pop,
	output logic nonempty,
	output mscs_pkg::uop_t head
);

	import mscs_pkg::*;

	uop_t slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_uop;
		end
	end

endmodule

// ===== hw/rtl/mscs_back.sv =====
`timescale 1ns / 1ps

module mscs_back (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mscs_pkg::BUDGET_W-1:0] cfg_wdata,
	input logic q_nonempty,
	input mscs_pkg::uop_t q_head,
	output logic q_pop,
	output logic m_valid,
	input logic m_ready,
	output mscs_pkg::result_t m_res,
	output logic busy
);

	import mscs_pkg::*;

	// pipeline control
	logic en;
	logic clearing;
	logic [CLR_CNT_W-1:0] clr_cnt_q;

	// architectural state
	logic [XLEN-1:0] pc_q;
	logic [BUDGET_W-1:0] budget_q;
	logic stopped_q;
	status_t stop_code_q;

	// execute stage
	logic x_v_s2;
	uop_t x_uop_s2;
	logic [XLEN-1:0] ra_rdata;
	logic [XLEN-1:0] rb_rdata;
	logic [XLEN-1:0] opa;
	logic [XLEN-1:0] opb;
	logic [XLEN-1:0] alu_b;
	logic [XLEN-1:0] alu_y;
	logic [XLEN-1:0] pc4;
	logic [XLEN-1:0] maddr;
	logic bad_addr;
	logic [DA_W-1:0] daddr;
	logic x_exec;
	logic x_load;
	result_t x_res;

	// memory-return stage and the write seen by the read just done
	logic s3_v_s3;
	logic s3_load_s3;
	result_t s3_res_s3;
	result_t s3_out;
	logic [XLEN-1:0] s3_val;
	logic [XLEN-1:0] dm_rdata;
	logic wb_we;
	logic wb_v_q;
	logic [REG_W-1:0] wb_idx_q;
	logic [XLEN-1:0] wb_val_q;

	// output register
	logic out_v_q;
	result_t out_res_q;

	// memory write ports
	logic rf_we;
	logic [REG_W-1:0] rf_waddr;
	logic [XLEN-1:0] rf_wdata;
	logic dm_we;
	logic [DA_W-1:0] dm_waddr;
	logic [XLEN-1:0] dm_wdata;

	assign en = !out_v_q || m_ready;
	assign clearing = (clr_cnt_q != CLR_CNT_W'(CLR_WORDS));
	assign busy = clearing;
	assign q_pop = en && q_nonempty && !clearing;
	assign m_valid = out_v_q;
	assign m_res = out_res_q;

	// register file: two copies give two read ports
	assign wb_we = en && s3_v_s3 && s3_res_s3.reg_write;
	assign rf_we = clearing || wb_we;
	assign rf_waddr = clearing ? clr_cnt_q[REG_W-1:0] : s3_res_s3.reg_index;
	assign rf_wdata = clearing ? '0 : s3_val;

	mscs_ram #(.WIDTH(XLEN), .DEPTH(REGS)) u_rf_a (
		.clk(clk),
		.we(rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.re(en),
		.raddr(q_head.rs),
		.rdata(ra_rdata)
	);

	mscs_ram #(.WIDTH(XLEN), .DEPTH(REGS)) u_rf_b (
		.clk(clk),
		.we(rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.re(en),
		.raddr(q_head.rt),
		.rdata(rb_rdata)
	);

	// data memory: stores write from execute, load data is registered and returns in the memory-return stage
	assign dm_we = clearing ? (clr_cnt_q < CLR_CNT_W'(DATA_WORDS))
		: (en && x_v_s2 && x_res.mem_write);
	assign dm_waddr = clearing ? clr_cnt_q[DA_W-1:0] : daddr;
	assign dm_wdata = clearing ? '0 : opb;

	mscs_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
		.clk(clk),
		.we(dm_we),
		.waddr(dm_waddr),
		.wdata(dm_wdata),
		.re(en),
		.raddr(daddr),
		.rdata(dm_rdata)
	);

	assign s3_val = s3_load_s3 ? dm_rdata : s3_res_s3.reg_value;

	// result leaving the memory-return stage, load data merged in
	always_comb begin
		s3_out = s3_res_s3;
		s3_out.reg_value = s3_val;
	end

	// operand bypass: the item just ahead, then the write made at the read edge
	always_comb begin
		if (s3_v_s3 && s3_res_s3.reg_write && s3_res_s3.reg_index == x_uop_s2.rs) begin
			opa = s3_val;
		end else if (wb_v_q && wb_idx_q == x_uop_s2.rs) begin
			opa = wb_val_q;
		end else begin
			opa = ra_rdata;
		end
		if (s3_v_s3 && s3_res_s3.reg_write && s3_res_s3.reg_index == x_uop_s2.rt) begin
			opb = s3_val;
		end else if (wb_v_q && wb_idx_q == x_uop_s2.rt) begin
			opb = wb_val_q;
		end else begin
			opb = rb_rdata;
		end
	end

	// alu
	assign alu_b = x_uop_s2.use_imm ? x_uop_s2.imm : opb;
	always_comb begin
		unique case (x_uop_s2.alu_op)
			A_ADD: alu_y = opa + alu_b;
			A_SUB: alu_y = opa - alu_b;
			A_AND: alu_y = opa & alu_b;
			A_OR: alu_y = opa | alu_b;
			A_SLT: alu_y = {31'b0, $signed(opa) < $signed(alu_b)};
			A_PASSB: alu_y = alu_b;
			default: alu_y = '0;
		endcase
	end

	// data address relative to the memory base
	assign pc4 = pc_q + 32'd4;
	assign maddr = opa + x_uop_s2.imm;
	assign bad_addr = (maddr[XLEN-1:2] >= 30'(DATA_WORDS));
	assign daddr = maddr[DA_W+1:2];

	// execute one instruction against pc, budget and stop state
	always_comb begin
		x_res.next_pc = pc4;
		x_res.reg_write = 1'b0;
		x_res.reg_index = '0;
		x_res.reg_value = '0;
		x_res.mem_write = 1'b0;
		x_res.mem_word_index = '0;
		x_res.mem_value = '0;
		x_res.status = ST_OK;
		x_exec = 1'b0;
		x_load = 1'b0;
		if (stopped_q) begin
			x_res.next_pc = pc_q;
			x_res.status = stop_code_q;
		end else if (budget_q == '0) begin
			x_res.next_pc = pc_q;
			x_res.status = ST_BUDGET;
		end else begin
			x_exec = 1'b1;
			unique case (x_uop_s2.kind)
				K_NOP: x_res.status = ST_OK;
				K_HALT: x_res.status = ST_HALT;
				K_BAD: x_res.status = ST_BAD_OP;
				K_ALU: begin
					x_res.reg_write = 1'b1;
					x_res.reg_index = x_uop_s2.dst;
					x_res.reg_value = alu_y;
				end
				K_JUMP: x_res.next_pc = {pc4[31:28], x_uop_s2.jidx, 2'b00};
				K_BEQ: begin
					if (opa == opb) begin
						x_res.next_pc = pc4 + {x_uop_s2.imm[29:0], 2'b00};
					end
				end
				K_BNE: begin
					if (opa != opb) begin
						x_res.next_pc = pc4 + {x_uop_s2.imm[29:0], 2'b00};
					end
				end
				K_LOAD: begin
					if (bad_addr) begin
						x_res.status = ST_BAD_ADDR;
					end else begin
						x_res.reg_write = 1'b1;
						x_res.reg_index = x_uop_s2.rt;
						x_load = 1'b1;
					end
				end
				K_STORE: begin
					if (bad_addr) begin
						x_res.status = ST_BAD_ADDR;
					end else begin
						x_res.mem_write = 1'b1;
						x_res.mem_word_index = maddr[MEM_IDX_W+1:2];
						x_res.mem_value = opb;
					end
				end
				default: x_res.status = ST_BAD_OP;
			endcase
			// register zero never changes
			if (x_res.reg_write && x_res.reg_index == '0) begin
				x_res.reg_write = 1'b0;
				x_res.reg_value = '0;
				x_load = 1'b0;
			end
		end
	end

	// control state, clear pass and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pc_q <= '0;
			budget_q <= '0;
			stopped_q <= 1'b0;
			stop_code_q <= ST_OK;
			x_v_s2 <= 1'b0;
			s3_v_s3 <= 1'b0;
			wb_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end else if (en && x_v_s2 && x_exec) begin
				budget_q <= budget_q - BUDGET_W'(1);
			end
			if (en && x_v_s2) begin
				if (x_exec) begin
					pc_q <= x_res.next_pc;
				end
				if (x_res.status != ST_OK && !stopped_q) begin
					stopped_q <= 1'b1;
					stop_code_q <= x_res.status;
				end
			end
			if (en) begin
				x_v_s2 <= q_pop;
				s3_v_s3 <= x_v_s2;
				wb_v_q <= wb_we;
				out_v_q <= s3_v_s3;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			x_uop_s2 <= q_head;
			s3_res_s3 <= x_res;
			s3_load_s3 <= x_load;
			wb_idx_q <= s3_res_s3.reg_index;
			wb_val_q <= s3_val;
			if (s3_v_s3) begin
				out_res_q <= s3_out;
			end
		end
	end

endmodule

// ===== hw/rtl/mips_subset_core_step_top.sv =====
`timescale 1ns / 1ps

// MIPS32 subset core that executes one instruction word per request on the input
// stream and returns one result per instruction: next pc, register write, store and
// status. Sustained rate is one instruction per clock while the output is not
// stalled and the clear pass is done. A request is registered in turn by the decode
// queue, register file read, execute with data memory read and output register. Loads
// and dependent instructions issue back to back through operand bypassing. After
// reset the core runs a clear pass over the register file and data memory, covering
// the larger of the two depths, with s_axis_tready low. The instruction budget is
// written through cfg_we / cfg_wdata while the core is idle; each write also reloads
// the remaining budget.

module mips_subset_core_step_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mscs_pkg::BUDGET_W-1:0] cfg_wdata, // instruction_budget[19:0]
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [mscs_pkg::IN_W-1:0] s_axis_tdata, // instruction[31:0]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// next_pc[31:0], reg_write[32], reg_index[37:33], reg_value[69:38],
	// mem_write[70], mem_word_index[80:71], mem_value[112:81], status[115:113]
	output logic [mscs_pkg::OUT_W-1:0] m_axis_tdata
);

	import mscs_pkg::*;

	logic busy;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_nonempty;
	uop_t dec_uop;
	uop_t q_head;
	result_t m_res;

	// decode and accept
	mscs_front u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.q_full(q_full),
		.busy(busy),
		.push(q_push),
		.uop(dec_uop)
	);

	// decoupling queue
	mscs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_uop(dec_uop),
		.full(q_full),
		.pop(q_pop),
		.nonempty(q_nonempty),
		.head(q_head)
	);

	// execute, memories and output register
	mscs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.q_nonempty(q_nonempty),
		.q_head(q_head),
		.q_pop(q_pop),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_res(m_res),
		.busy(busy)
	);

	// pack the result, last struct field (next_pc) lowest, upper bits zero
	assign m_axis_tdata = {{(OUT_W - RES_W){1'b0}}, m_res};

	// no request taken during the clear pass
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_axis_tready)
		else $error("request accepted during memory clear pass");

	// register zero is never reported as written
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_res.reg_write |-> m_res.reg_index != '0)
		else $error("write to register zero reported");

	// a stopping status carries no side effects
	a_stop_no_writes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_res.status != ST_OK |-> !m_res.reg_write && !m_res.mem_write)
		else $error("write reported with non-zero status");

	// an instruction writes a register or memory, never both
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_res.reg_write && m_res.mem_write))
		else $error("register and memory write in one result");

endmodule

// ===== verif/mips_subset_core_step_top_tb.sv =====
`timescale 1ns / 1ps

module mips_subset_core_step_top_tb;
	import mscs_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [BUDGET_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata; // instruction[31:0]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// next_pc[31:0], reg_write[32], reg_index[37:33], reg_value[69:38],
	// mem_write[70], mem_word_index[80:71], mem_value[112:81], status[115:113]
	logic [OUT_W-1:0] m_axis_tdata;

	// architectural state as the core should hold it
	logic [XLEN-1:0] arch_pc;
	logic [XLEN-1:0] arch_regs [0:REGS-1];
	logic [XLEN-1:0] arch_mem [0:DATA_WORDS-1];
	logic [BUDGET_W-1:0] budget_remaining;
	logic is_stopped;
	status_t stop_status;

	result_t pending_results [$];
	result_t seen_result;
	result_t due_result;
	logic rx_took = 1'b0;
	int mismatches = 0;
	int tx_calm = 0;
	int rx_calm = 0;
	int rx_stall = 0;

	mips_subset_core_step_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// idle cycles before the next request, with runs of back-to-back traffic
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			calm = $urandom_range(10, 40);
		return $urandom_range(0, 8);
	endfunction

	function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
			input logic [4:0] rt, input logic [4:0] rd);
		return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_j(input logic [25:0] idx);
		return {OP_J, idx};
	endfunction

	// mostly a few hot registers so that results feed each other
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, 7));
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// executes one instruction word on the architectural state
	function automatic result_t execute_word(input logic [31:0] ins);
		result_t r;
		logic [31:0] pc4, a, b, simm, uimm, off, widx;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd;
		r = '0;
		pc4 = arch_pc + 32'd4;
		r.next_pc = pc4;
		r.status = ST_OK;
		if (is_stopped) begin
			r.next_pc = arch_pc;
			r.status = stop_status;
		end else if (budget_remaining == '0) begin
			r.next_pc = arch_pc;
			r.status = ST_BUDGET;
		end else begin
			op = ins[31:26];
			rs = ins[25:21];
			rt = ins[20:16];
			rd = ins[15:11];
			fn = ins[5:0];
			a = arch_regs[rs];
			b = arch_regs[rt];
			simm = {{16{ins[15]}}, ins[15:0]};
			uimm = {16'd0, ins[15:0]};
			budget_remaining = budget_remaining - BUDGET_W'(1);
			if (ins == INS_HALT) begin
				r.status = ST_HALT;
			end else if (ins == INS_NOP) begin
				r.status = ST_OK;
			end else if (op == OP_RTYPE) begin
				r.reg_write = 1'b1;
				r.reg_index = rd;
				case (fn)
					FN_ADD: r.reg_value = a + b;
					FN_SUB: r.reg_value = a - b;
					FN_AND: r.reg_value = a & b;
					FN_OR: r.reg_value = a | b;
					FN_SLT: r.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
					default: begin
						r.reg_write = 1'b0;
						r.reg_index = '0;
						r.status = ST_BAD_OP;
					end
				endcase
			end else if (op == OP_J) begin
				r.next_pc = {pc4[31:28], ins[25:0], 2'b00};
			end else if (op == OP_BEQ || op == OP_BNE) begin
				if ((a == b) == (op == OP_BEQ))
					r.next_pc = pc4 + (simm << 2);
			end else if (op == OP_LW || op == OP_SW) begin
				off = a + simm - DATA_BASE;
				widx = off >> 2;
				if (widx >= DATA_WORDS) begin
					r.status = ST_BAD_ADDR;
				end else if (op == OP_LW) begin
					r.reg_write = 1'b1;
					r.reg_index = rt;
					r.reg_value = arch_mem[widx];
				end else begin
					arch_mem[widx] = b;
					r.mem_write = 1'b1;
					r.mem_word_index = widx[MEM_IDX_W-1:0];
					r.mem_value = b;
				end
			end else begin
				r.reg_write = 1'b1;
				r.reg_index = rt;
				case (op)
					OP_ADDI: r.reg_value = a + simm;
					OP_SLTI: r.reg_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
					OP_ANDI: r.reg_value = a & uimm;
					OP_ORI: r.reg_value = a | uimm;
					OP_LUI: r.reg_value = uimm << 16;
					default: begin
						r.reg_write = 1'b0;
						r.reg_index = '0;
						r.status = ST_BAD_OP;
					end
				endcase
			end
			// register zero never changes
			if (r.reg_write && r.reg_index == '0) begin
				r.reg_write = 1'b0;
				r.reg_value = '0;
			end
			if (r.reg_write)
				arch_regs[r.reg_index] = r.reg_value;
			arch_pc = r.next_pc;
		end
		if (r.status != ST_OK && !is_stopped) begin
			is_stopped = 1'b1;
			stop_status = r.status;
		end
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %h, got %h", name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rx_took = arst_n && m_axis_tvalid && m_axis_tready;
		if (rx_took) begin
			seen_result = result_t'(m_axis_tdata[RES_W-1:0]);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h with nothing pending", seen_result);
			end else begin
				due_result = pending_results.pop_front();
				compare_field("next_pc", due_result.next_pc, seen_result.next_pc);
				compare_field("reg_write", 32'(due_result.reg_write),
					32'(seen_result.reg_write));
				compare_field("reg_index", 32'(due_result.reg_index),
					32'(seen_result.reg_index));
				compare_field("reg_value", due_result.reg_value, seen_result.reg_value);
				compare_field("mem_write", 32'(due_result.mem_write),
					32'(seen_result.mem_write));
				compare_field("mem_word_index", 32'(due_result.mem_word_index),
					32'(seen_result.mem_word_index));
				compare_field("mem_value", due_result.mem_value, seen_result.mem_value);
				compare_field("status", 32'(due_result.status), 32'(seen_result.status));
			end
		end
	end

	// output stall draw after each taken result, ready follows it
	always @(negedge clk) begin
		if (rx_took)
			rx_stall = draw_idle(rx_calm);
		if (rx_stall > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// one instruction request; entered and left at a falling edge
	task automatic send_word(input logic [31:0] ins);
		int gap;
		gap = draw_idle(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ins;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(execute_word(ins));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_budget(input logic [BUDGET_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		budget_remaining = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// signed extremes, wrap, zero extension and writes to register zero
	task automatic test_alu_extremes();
		send_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
		send_word(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
		send_word(enc_i(OP_LUI, 5'd0, 5'd2, 16'h8000));
		send_word(enc_r(FN_ADD, 5'd1, 5'd1, 5'd3));
		send_word(enc_r(FN_SUB, 5'd2, 5'd1, 5'd4));
		send_word(enc_r(FN_AND, 5'd1, 5'd2, 5'd5));
		send_word(enc_r(FN_OR, 5'd1, 5'd2, 5'd5));
		send_word(enc_r(FN_SLT, 5'd2, 5'd1, 5'd6));
		send_word(enc_r(FN_SLT, 5'd1, 5'd2, 5'd6));
		send_word(enc_i(OP_ADDI, 5'd0, 5'd7, 16'hFFFF));
		send_word(enc_i(OP_SLTI, 5'd7, 5'd8, 16'h0000));
		send_word(enc_i(OP_ANDI, 5'd7, 5'd9, 16'hFFFF));
		send_word(enc_i(OP_ORI, 5'd0, 5'd9, 16'h8000));
		send_word(enc_r(FN_ADD, 5'd1, 5'd1, 5'd0));
	endtask

	// first and last data word, unaligned address, load into register zero
	task automatic test_memory_edges();
		send_word(enc_i(OP_LUI, 5'd0, 5'd10, 16'h1000));
		send_word(enc_i(OP_SW, 5'd10, 5'd7, 16'h0FFC));
		send_word(enc_i(OP_SW, 5'd10, 5'd1, 16'h0000));
		send_word(enc_i(OP_SW, 5'd10, 5'd2, 16'h0800));
		send_word(enc_i(OP_LW, 5'd10, 5'd11, 16'h0FFC));
		send_word(enc_i(OP_LW, 5'd10, 5'd12, 16'h0003));
		send_word(enc_i(OP_LW, 5'd10, 5'd0, 16'h0800));
	endtask

	// taken and untaken branches, widest forward offset and jump targets, nop
	task automatic test_control_flow();
		send_word(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFF));
		send_word(enc_i(OP_BNE, 5'd1, 5'd1, 16'h0005));
		send_word(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
		send_word(enc_j(26'h3FF_FFFF));
		send_word(enc_j(26'h000_0000));
		send_word(INS_NOP);
	endtask

	// well-formed random instructions that never stop the core
	task automatic test_random_program(input int count);
		int sent, pick, t;
		logic [4:0] rs, rt, rd;
		logic [5:0] op, fn;
		logic [31:0] imm32;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			rs = pick_reg();
			rt = pick_reg();
			rd = pick_reg();
			if (pick < 30) begin
				case ($urandom_range(0, 4))
					0: fn = FN_ADD;
					1: fn = FN_SUB;
					2: fn = FN_AND;
					3: fn = FN_OR;
					default: fn = FN_SLT;
				endcase
				send_word(enc_r(fn, rs, rt, rd) | {21'd0, 5'($urandom), 6'd0});
			end else if (pick < 48) begin
				case ($urandom_range(0, 4))
					0: op = OP_ADDI;
					1: op = OP_SLTI;
					2: op = OP_ANDI;
					3: op = OP_ORI;
					default: op = OP_LUI;
				endcase
				send_word(enc_i(op, rs, rt, pick_imm()));
			end else if (pick < 72) begin
				// address inside data memory, reusing a few words often
				t = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
				imm32 = DATA_BASE + 32'(t) - arch_regs[rs];
				if ($signed(imm32) < -32768 || $signed(imm32) > 32767) begin
					if (rs == 5'd0)
						rs = 5'($urandom_range(1, 31));
					send_word(enc_i(OP_LUI, 5'd0, rs, 16'h1000));
					sent++;
					imm32 = 32'(t);
				end
				op = $urandom_range(0, 1) ? OP_LW : OP_SW;
				send_word(enc_i(op, rs, rt, imm32[15:0]));
			end else if (pick < 87) begin
				if ($urandom_range(0, 2) == 0)
					rt = rs;
				op = $urandom_range(0, 1) ? OP_BEQ : OP_BNE;
				send_word(enc_i(op, rs, rt, pick_imm()));
			end else if (pick < 96) begin
				send_word(enc_j(26'($urandom)));
			end else begin
				send_word(INS_NOP);
			end
			sent++;
		end
	endtask

	task automatic test_budget_reload();
		wait_idle();
		write_budget(BUDGET_W'($urandom_range(800, 900000)));
	endtask

	// one stop cause per run, then requests that must find the core stopped
	task automatic test_stop_condition();
		int cause, k;
		logic [5:0] op, fn;
		logic [31:0] ins;
		cause = $urandom_range(0, 4);
		test_random_program($urandom_range(3, 8));
		case (cause)
			0: send_word(INS_HALT);
			1: begin
				if ($urandom_range(0, 1)) begin
					do begin
						op = 6'($urandom_range(0, 63));
						ins = {op, 26'($urandom)};
					end while (op == OP_RTYPE || op == OP_J || op == OP_BEQ ||
						op == OP_BNE || op == OP_ADDI || op == OP_SLTI ||
						op == OP_ANDI || op == OP_ORI || op == OP_LUI ||
						op == OP_LW || op == OP_SW || ins == INS_HALT);
				end else begin
					do
						fn = 6'($urandom_range(0, 63));
					while (fn == FN_ADD || fn == FN_SUB || fn == FN_AND ||
						fn == FN_OR || fn == FN_SLT);
					ins = enc_r(fn, 5'd1, pick_reg(), pick_reg());
				end
				send_word(ins);
			end
			2: begin
				op = $urandom_range(0, 1) ? OP_LW : OP_SW;
				if ($urandom_range(0, 1)) begin
					send_word(enc_i(op, 5'd0, pick_reg(), 16'h0000));
				end else begin
					send_word(enc_i(OP_LUI, 5'd0, 5'd13, 16'h1000));
					send_word(enc_i(op, 5'd13, pick_reg(), 16'h1000));
				end
			end
			3: begin
				k = $urandom_range(1, 6);
				wait_idle();
				write_budget(BUDGET_W'(k));
				test_random_program(k);
			end
			default: begin
				wait_idle();
				write_budget('0);
			end
		endcase
		repeat (8) send_word($urandom);
	endtask

	initial begin
		#5_000_000;
		$display("mips_subset_core_step_top test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		arch_pc = '0;
		for (int i = 0; i < REGS; i++)
			arch_regs[i] = '0;
		for (int i = 0; i < DATA_WORDS; i++)
			arch_mem[i] = '0;
		budget_remaining = '0;
		is_stopped = 1'b0;
		stop_status = ST_OK;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_budget({BUDGET_W{1'b1}});
		test_alu_extremes();
		test_memory_edges();
		test_control_flow();
		test_random_program(660);
		test_budget_reload();
		test_random_program(660);
		test_stop_condition();
		wait_idle();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("mips_subset_core_step_top test passed");
		else
			$display("mips_subset_core_step_top test failed");
		$finish;
	end

endmodule
